@@ hw/rtl/stb_pkg.sv @@
`timescale 1ns / 1ps

package stb_pkg;

  // Field widths of the stream payloads
  localparam int OP_W       = 3;
  localparam int ID_W       = 4;
  localparam int AMT_W      = 32;
  localparam int KIND_W     = 2;
  localparam int SLOT_W     = 4;
  localparam int STAT_W     = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  // At most this many expiries are reported per tick
  localparam int REPORT_MAX = 16;
  localparam int REP_W      = 5;

  // Command opcodes
  localparam logic [OP_W-1:0] OP_START    = 3'd0;
  localparam logic [OP_W-1:0] OP_STOP     = 3'd1;
  localparam logic [OP_W-1:0] OP_RESET    = 3'd2;
  localparam logic [OP_W-1:0] OP_TICK_TO  = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK_DEL = 3'd4;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE    = 2'd3;

  // Command status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_BUSY = 2'd1;
  localparam logic [STAT_W-1:0] ST_IDLE = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [STAT_W-1:0] status;
    logic              last;
  } result_t;

endpackage

@@ hw/rtl/software_timer_bank.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Payload
// s_*       in   tdata: op[2:0], timer_id[6:3], amount[38:7], zero pad[39]
// m_*       out  tdata: slot[3:0], status[5:4], zero pad[7:6]; tuser: kind; tlast: last
//
// The status of a start, stop or reset is loaded into the output
// register at the edge that accepts it.
// A tick sweeps one slot per cycle, unless stalled on a held expiry, through a read, modify,
// write of the remaining-count RAM, then gives the done result.
// Reset clears the running flags at once; the RAM needs no clearing pass.
// The sweep halts on an expiry to be reported while the output register is still held.
module software_timer_bank import stb_pkg::*; #(
  parameter int NUM_TIMERS  = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // op, timer_id, amount (low to high)
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // slot, status (low to high)
  output logic [KIND_W-1:0]     m_tuser,   // kind
  output logic                  m_tlast
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic                   out_free;
  logic                   emit_valid;
  result_t                emit;
  result_t                out_res;
  logic [IW-1:0]          rd_addr;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;

  assign out_free = !m_tvalid || m_tready;

  stb_core #(
    .NUM_TIMERS  (NUM_TIMERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .op         (s_tdata[OP_W-1:0]),
    .timer_id   (s_tdata[OP_W+ID_W-1:OP_W]),
    .amount     (s_tdata[OP_W+ID_W+AMT_W-1:OP_W+ID_W]),
    .out_free   (out_free),
    .emit_valid (emit_valid),
    .emit       (emit),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  stb_mem #(
    .DEPTH (NUM_TIMERS),
    .WIDTH (COUNT_WIDTH),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Hold each result until the downstream transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid) begin
      out_res <= emit;
    end
  end

  assign m_tdata = {(OUT_DATA_W - SLOT_W - STAT_W)'(0), out_res.status, out_res.slot};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

`ifndef SYNTHESIS
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_DONE |-> m_tlast)
    else $error("tick done result without last");

  a_expiry_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_TIMEOUT || m_tuser == KIND_DELETE)
      |-> !m_tlast && m_tdata[5:4] == ST_OK)
    else $error("expiry result carries last or an error status");

  a_cmd_status: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !(s_tdata[2:0] == OP_TICK_TO || s_tdata[2:0] == OP_TICK_DEL)
      |=> m_tvalid && m_tuser == KIND_STATUS && m_tlast)
    else $error("command status result missing");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !m_tvalid || m_tready)
    else $error("input accepted while a result is still held");
`endif

endmodule

@@ hw/rtl/stb_mem.sv @@
`timescale 1ns / 1ps

module stb_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/stb_core.sv @@
`timescale 1ns / 1ps

module stb_core import stb_pkg::*; #(
  parameter int NUM_TIMERS  = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OP_W-1:0]        op,
  input  logic [ID_W-1:0]        timer_id,
  input  logic [AMT_W-1:0]       amount,
  input  logic                   out_free,
  output logic                   emit_valid,
  output result_t                emit,
  output logic [(NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1)-1:0] rd_addr,
  input  logic [COUNT_WIDTH-1:0] rd_data,
  output logic                   wr_en,
  output logic [(NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1)-1:0] wr_addr,
  output logic [COUNT_WIDTH-1:0] wr_data
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int EW = (COUNT_WIDTH > AMT_W) ? COUNT_WIDTH : AMT_W;
  localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_TICK = 1'b1;

  logic [0:0]             state;
  logic [NUM_TIMERS-1:0]  running;
  logic [AMT_W-1:0]       tick_amount;
  logic [KIND_W-1:0]      tick_kind;
  logic                   proc_valid;
  logic [IW-1:0]          proc_idx;
  logic [IW-1:0]          rd_idx;
  logic                   rd_more;
  logic [REP_W-1:0]       rep_cnt;

  logic                   accept;
  logic                   is_tick;
  logic                   id_ok;
  logic [IW-1:0]          id_idx;
  logic                   id_run;
  logic [COUNT_WIDTH-1:0] start_count;
  logic [STAT_W-1:0]      cmd_status;
  logic                   cmd_write;

  logic                   p_run;
  logic                   p_never;
  logic                   p_gt;
  logic                   p_dec;
  logic                   p_exp;
  logic                   p_rep;
  logic                   advance;
  logic [EW-1:0]          p_diff;

  // Decode the incoming command
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign is_tick  = (op == OP_TICK_TO) || (op == OP_TICK_DEL);
  assign id_ok    = (32'(timer_id) < NUM_TIMERS);
  assign id_idx   = IW'(timer_id);
  assign id_run   = running[id_idx];

  // Clamp the start count; zero arms a never-expiring slot
  always_comb begin
    if (amount == '0) begin
      start_count = CMAX;
    end else if (EW'(amount) > EW'(CMAX)) begin
      start_count = CMAX - COUNT_WIDTH'(1);
    end else begin
      start_count = COUNT_WIDTH'(amount);
    end
  end

  always_comb begin
    cmd_status = ST_OK;
    if (id_ok) begin
      if (op == OP_START && id_run) begin
        cmd_status = ST_BUSY;
      end else if (op == OP_STOP && !id_run) begin
        cmd_status = ST_IDLE;
      end
    end
  end

  assign cmd_write = accept && !is_tick && id_ok &&
                     ((op == OP_START && !id_run) || op == OP_RESET);

  // Evaluate the slot whose count is on the read port
  assign p_run   = running[proc_idx];
  assign p_never = (rd_data == CMAX);
  assign p_gt    = EW'(rd_data) > EW'(tick_amount);
  assign p_dec   = proc_valid && p_run && !p_never && p_gt;
  assign p_exp   = proc_valid && p_run && !p_never && !p_gt;
  assign p_rep   = p_exp && (rep_cnt < REP_W'(REPORT_MAX));
  assign advance = !(p_rep && !out_free);
  assign p_diff  = EW'(rd_data) - EW'(tick_amount);

  // Re-read the held slot while the sweep is stalled
  always_comb begin
    if (state == S_TICK) begin
      rd_addr = advance ? rd_idx : proc_idx;
    end else begin
      rd_addr = '0;
    end
  end

  // Write back a decremented count or a freshly started one
  always_comb begin
    if (state == S_TICK) begin
      wr_en   = advance && p_dec;
      wr_addr = proc_idx;
      wr_data = COUNT_WIDTH'(p_diff);
    end else begin
      wr_en   = cmd_write;
      wr_addr = id_idx;
      wr_data = start_count;
    end
  end

  // Build the result for the output register
  always_comb begin
    emit_valid  = 1'b0;
    emit.kind   = KIND_STATUS;
    emit.slot   = '0;
    emit.status = ST_OK;
    emit.last   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept && !is_tick) begin
          emit_valid  = 1'b1;
          emit.slot   = timer_id;
          emit.status = cmd_status;
          emit.last   = 1'b1;
        end
      end
      S_TICK: begin
        if (proc_valid) begin
          if (p_rep && out_free) begin
            emit_valid = 1'b1;
            emit.kind  = tick_kind;
            emit.slot  = SLOT_W'(proc_idx);
          end
        end else if (out_free) begin
          emit_valid = 1'b1;
          emit.kind  = KIND_DONE;
          emit.last  = 1'b1;
        end
      end
      default: begin
        emit_valid = 1'b0;
      end
    endcase
  end

  // Sequence commands and the tick sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      running    <= '0;
      proc_valid <= 1'b0;
      rd_more    <= 1'b0;
      rep_cnt    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_tick) begin
              state       <= S_TICK;
              tick_amount <= amount;
              tick_kind   <= (op == OP_TICK_TO) ? KIND_TIMEOUT : KIND_DELETE;
              proc_valid  <= 1'b1;
              proc_idx    <= '0;
              rd_idx      <= (NUM_TIMERS > 1) ? IW'(1) : '0;
              rd_more     <= (NUM_TIMERS > 1);
              rep_cnt     <= '0;
            end else if (id_ok) begin
              if ((op == OP_START && !id_run) || op == OP_RESET) begin
                running[id_idx] <= 1'b1;
              end else if (op == OP_STOP) begin
                running[id_idx] <= 1'b0;
              end
            end
          end
        end
        S_TICK: begin
          if (proc_valid) begin
            if (advance) begin
              if (p_exp) begin
                running[proc_idx] <= 1'b0;
              end
              if (p_rep) begin
                rep_cnt <= rep_cnt + REP_W'(1);
              end
              proc_valid <= rd_more;
              proc_idx   <= rd_idx;
              if (rd_idx == IW'(NUM_TIMERS - 1)) begin
                rd_more <= 1'b0;
              end else begin
                rd_idx <= rd_idx + IW'(1);
              end
            end
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import stb_pkg::*;

  localparam int               NUM_SLOTS   = 16;
  localparam logic [AMT_W-1:0] NEVER_COUNT = '1;
  localparam int               CYCLE_LIMIT = 600000;
  localparam int               DRAIN_WAIT  = 40;

  // Opcodes outside the defined command set
  localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;    // op, timer_id, amount (low to high)
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;         // slot, status (low to high)
  logic [KIND_W-1:0]     m_tuser;         // kind
  logic                  m_tlast;

  // Shadow copy of the timer bank
  logic             slot_armed [NUM_SLOTS];
  logic [AMT_W-1:0] slot_count [NUM_SLOTS];
  result_t          pending_results [$];

  int  items_sent      = 0;
  int  results_checked = 0;
  int  expiries_seen   = 0;
  int  errors          = 0;
  int  cycle_cnt       = 0;
  int  stall_left      = 0;
  bit  quiet           = 1'b0;
  result_t got_result;
  result_t want_result;

  software_timer_bank u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Clock generation
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending", cycle_cnt,
               pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Throttle the result side in bursts
  always @(posedge clk) begin
    if (rst || quiet) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic result_t make_result(input logic [KIND_W-1:0] kind,
                                          input logic [SLOT_W-1:0] slot,
                                          input logic [STAT_W-1:0] status,
                                          input logic last);
    result_t r;
    r.kind   = kind;
    r.slot   = slot;
    r.status = status;
    r.last   = last;
    return r;
  endfunction

  // Load a slot with its count; zero means never expire
  function automatic void arm_slot(input logic [ID_W-1:0] id, input logic [AMT_W-1:0] amt);
    slot_armed[id] = 1'b1;
    slot_count[id] = (amt == '0) ? NEVER_COUNT : amt;
  endfunction

  function automatic void disarm_slot(input logic [ID_W-1:0] id);
    slot_armed[id] = 1'b0;
    slot_count[id] = '0;
  endfunction

  // Work out the results of one accepted transaction
  function automatic void predict_results(input logic [IN_DATA_W-1:0] d);
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   id;
    logic [AMT_W-1:0]  amt;
    logic [KIND_W-1:0] exp_kind;
    logic [STAT_W-1:0] status;
    op  = d[OP_W-1:0];
    id  = d[OP_W+ID_W-1:OP_W];
    amt = d[OP_W+ID_W+AMT_W-1:OP_W+ID_W];
    if (op == OP_TICK_TO || op == OP_TICK_DEL) begin
      exp_kind = (op == OP_TICK_TO) ? KIND_TIMEOUT : KIND_DELETE;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_armed[i] && slot_count[i] != NEVER_COUNT) begin
          if (slot_count[i] > amt) begin
            slot_count[i] = slot_count[i] - amt;
          end else begin
            disarm_slot(ID_W'(i));
            pending_results.push_back(make_result(exp_kind, SLOT_W'(i), ST_OK, 1'b0));
          end
        end
      end
      pending_results.push_back(make_result(KIND_DONE, '0, ST_OK, 1'b1));
    end else begin
      status = ST_OK;
      case (op)
        OP_START: begin
          if (slot_armed[id]) status = ST_BUSY;
          else arm_slot(id, amt);
        end
        OP_STOP: begin
          if (!slot_armed[id]) status = ST_IDLE;
          else disarm_slot(id);
        end
        OP_RESET: begin
          disarm_slot(id);
          arm_slot(id, amt);
        end
        default: ;
      endcase
      pending_results.push_back(make_result(KIND_STATUS, id, status, 1'b1));
    end
  endfunction

  // Clear the shadow bank in reset, then track accepted input transactions
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) disarm_slot(ID_W'(i));
    end else if (s_tvalid && s_tready) begin
      predict_results(s_tdata);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_result.kind   = m_tuser;
      got_result.slot   = m_tdata[SLOT_W-1:0];
      got_result.status = m_tdata[SLOT_W+STAT_W-1:SLOT_W];
      got_result.last   = m_tlast;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0d slot=%0d status=%0d last=%0d", $time,
                 got_result.kind, got_result.slot, got_result.status, got_result.last);
      end else begin
        want_result = pending_results.pop_front();
        results_checked++;
        if (got_result.kind == KIND_TIMEOUT || got_result.kind == KIND_DELETE)
          expiries_seen++;
        if (got_result.kind !== want_result.kind || got_result.slot !== want_result.slot ||
            got_result.status !== want_result.status || got_result.last !== want_result.last)
        begin
          errors++;
          $display("%0t: mismatch expected kind=%0d slot=%0d status=%0d last=%0d,",
                   $time, want_result.kind, want_result.slot, want_result.status,
                   want_result.last, " actual kind=%0d slot=%0d status=%0d last=%0d",
                   got_result.kind, got_result.slot, got_result.status, got_result.last);
        end
      end
    end
  end

  // Offer one command or tick, with an optional idle burst in front
  task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                           input logic [AMT_W-1:0] amt);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {1'b0, amt, id, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Hold off the sender until every expected result is back
  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [AMT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return NEVER_COUNT;
      2:       return $urandom;
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  function automatic logic [AMT_W-1:0] pick_elapsed();
    case ($urandom_range(0, 11))
      0:       return $urandom;
      1:       return NEVER_COUNT;
      2:       return '0;
      default: return $urandom_range(1, 15);
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_tick();
    return ($urandom_range(0, 1) == 0) ? OP_TICK_TO : OP_TICK_DEL;
  endfunction

  // Arm, stop or reset a few slots, then run ticks over them
  task automatic run_sequence();
    int arms;
    int ticks;
    arms  = $urandom_range(1, 6);
    ticks = $urandom_range(1, 3);
    repeat (arms) begin
      case ($urandom_range(0, 7))
        0:       send_item(OP_STOP, ID_W'($urandom), $urandom);
        1:       send_item(OP_RESET, ID_W'($urandom), pick_count());
        default: send_item(OP_START, ID_W'($urandom), pick_count());
      endcase
    end
    repeat (ticks) send_item(pick_tick(), ID_W'($urandom), pick_elapsed());
  endtask

  // Corners of every command, skipped slots and undefined ops
  task automatic test_command_corners();
    send_item(OP_START, 4'd0, '0);
    send_item(OP_START, 4'd15, NEVER_COUNT);
    send_item(OP_START, 4'd1, 32'd1);
    send_item(OP_START, 4'd1, 32'd7);
    send_item(OP_STOP, 4'd2, 32'd0);
    send_item(OP_RESET, 4'd3, 32'd5);
    send_item(OP_RESET, 4'd1, 32'd10);
    send_item(OP_START, 4'd4, 32'hFFFF_FFFE);
    send_item(OP_TICK_TO, 4'd0, '0);
    send_item(OP_TICK_TO, 4'd15, 32'd5);
    send_item(OP_TICK_DEL, 4'd7, NEVER_COUNT);
    send_item(OP_STOP, 4'd0, NEVER_COUNT);
    send_item(OP_STOP, 4'd15, 32'd0);
    send_item(OP_STOP, 4'd15, 32'd0);
    send_item(OP_UNDEF_LO, 4'd9, $urandom);
    send_item(OP_UNDEF_HI, 4'd6, NEVER_COUNT);
    send_item(OP_TICK_DEL, 4'd10, 32'd3);
    wait_all_results();
  endtask

  // Every slot expires on one tick
  task automatic test_full_bank_expiry();
    for (int i = 0; i < NUM_SLOTS; i++) send_item(OP_START, ID_W'(i), AMT_W'(i + 1));
    send_item(OP_TICK_TO, 4'd0, 32'd16);
    wait_all_results();
  endtask

  task automatic test_tick_sequences();
    while (items_sent < 290) begin
      run_sequence();
      if ($urandom_range(0, 15) == 0) wait_all_results();
    end
  endtask

  // Unordered mix of any op with any field values
  task automatic test_random_mix();
    while (items_sent < 335) begin
      if ($urandom_range(0, 19) == 0)
        send_item(OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI)), ID_W'($urandom), $urandom);
      else
        send_item(OP_W'($urandom_range(OP_START, OP_TICK_DEL)), ID_W'($urandom),
                  ($urandom_range(0, 1) == 0) ? $urandom : pick_count());
    end
  endtask

  task automatic test_quiet_tail();
    quiet = 1'b1;
    while (items_sent < 380) run_sequence();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_command_corners();
    test_full_bank_expiry();
    test_tick_sequences();
    test_random_mix();
    test_quiet_tail();
    wait_all_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Sent %0d transactions (starts, stops, resets, both tick kinds, undefined ops);",
             items_sent);
    $display("checked %0d results including %0d expiries, with stalls on both sides.",
             results_checked, expiries_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d errors", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/stb_pkg.sv
hw/rtl/stb_mem.sv
hw/rtl/stb_core.sv
hw/rtl/software_timer_bank.sv
test/tb_top.sv
